>>> hdl/e2q_pkg.sv
// Shared types, constants and tables for the Euler angle to quaternion converter.
package e2q_pkg;

  // Build options
  localparam int CORDIC_STAGES = 16;
  localparam int OUT_FRAC_BITS = 14;

  // The arctangent table holds 24 entries; stages beyond that are not built
  localparam int ATAN_LEN = 24;
  localparam int CORDIC_N = (CORDIC_STAGES > ATAN_LEN) ? ATAN_LEN : CORDIC_STAGES;

  // Half-angle front end: saturate, multiply, reciprocal, sign
  localparam int ANG_STAGES = 4;
  localparam int LANE_DEPTH = ANG_STAGES + CORDIC_N;
  // Merge adds the pair-product and triple-product stages
  localparam int PIPE_DEPTH = LANE_DEPTH + 2;

  // CORDIC datapath width (Q30 with headroom for gain and sign)
  localparam int CW = 34;

  localparam logic signed [15:0] ANG_LIMIT = 16'sd23040;

  // Half angle in Q30: round(|a| * PI_Q30 / 46080), with PI_Q30 = q * 46080 + r
  localparam longint PI_Q30       = 64'd3373259426;
  localparam longint HALF_DEG_DIV = 64'd46080;
  localparam logic [16:0] HALF_Q  = 17'(PI_Q30 / HALF_DEG_DIV);
  localparam logic [14:0] HALF_R  = 15'(PI_Q30 % HALF_DEG_DIV);
  localparam logic [28:0] HALF_RND = 29'(HALF_DEG_DIV / 2);
  // 46080 = 1024 * 45; divide by 45 through a reciprocal, exact below 2^19
  localparam int     DIV_SHIFT    = 10;
  localparam longint DIV_ODD      = HALF_DEG_DIV / 1024;
  localparam int     RECIP_SHIFT  = 25;
  localparam logic [19:0] RECIP_45 = 20'(((64'd1 << RECIP_SHIFT) + DIV_ODD - 1) / DIV_ODD);

  localparam logic signed [CW-1:0] GAIN_Q30 = 34'sd652032874;
  localparam logic signed [CW-1:0] ONE_Q30  = 34'sd1 <<< 30;

  typedef struct packed {
    logic signed [15:0] angle_roll;
    logic signed [15:0] angle_pitch;
    logic signed [15:0] angle_yaw;
  } angles_t;

  typedef struct packed {
    logic signed [15:0] quat_real;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
  } quat_t;

  // Arctangent of 2^-i in Q30, truncated
  function automatic logic [31:0] atan_q30(input int idx);
    logic [31:0] v;
    case (idx)
      0:       v = 32'h3243F6A8;
      1:       v = 32'h1DAC6705;
      2:       v = 32'h0FADBAFC;
      3:       v = 32'h07F56EA6;
      4:       v = 32'h03FEAB76;
      5:       v = 32'h01FFD55B;
      6:       v = 32'h00FFFAAA;
      7:       v = 32'h007FFF55;
      8:       v = 32'h003FFFEA;
      9:       v = 32'h001FFFFD;
      10:      v = 32'h000FFFFF;
      11:      v = 32'h0007FFFF;
      12:      v = 32'h0003FFFF;
      13:      v = 32'h0001FFFF;
      14:      v = 32'h0000FFFF;
      15:      v = 32'h00007FFF;
      16:      v = 32'h00003FFF;
      17:      v = 32'h00001FFF;
      18:      v = 32'h00000FFF;
      19:      v = 32'h000007FF;
      20:      v = 32'h000003FF;
      21:      v = 32'h000001FF;
      22:      v = 32'h000000FF;
      23:      v = 32'h0000007F;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

>>> hdl/e2q_lane.sv
// One angle lane: half angle in Q30, then a pipelined CORDIC for cosine and sine.
module e2q_lane
  import e2q_pkg::*;
(
  input  logic               clk,
  input  logic               en,
  input  logic signed [15:0] angle,
  output logic signed [31:0] cos_q30,
  output logic signed [31:0] sin_q30
);

  logic signed [15:0] a_sat;
  logic signed [15:0] a_abs;

  logic [14:0] mag_r;
  logic        neg0_r, neg1_r, neg2_r;
  logic [30:0] mq_r, mq_nxt, mq2_r;
  logic [28:0] rm_r, rm_nxt;
  logic [38:0] qprod;
  logic [13:0] quo_r;
  logic [30:0] theta_sum;
  logic signed [CW-1:0] theta_r, theta_nxt;

  logic signed [CW-1:0] cx_r [CORDIC_N];
  logic signed [CW-1:0] cy_r [CORDIC_N];
  logic signed [CW-1:0] cz_r [CORDIC_N];
  logic signed [CW-1:0] xin  [CORDIC_N];
  logic signed [CW-1:0] yin  [CORDIC_N];
  logic signed [CW-1:0] zin  [CORDIC_N];

  // Saturate to +-180 degrees and take the magnitude
  always_comb begin
    if (angle > ANG_LIMIT) begin
      a_sat = ANG_LIMIT;
    end else if (angle < -ANG_LIMIT) begin
      a_sat = -ANG_LIMIT;
    end else begin
      a_sat = angle;
    end
    a_abs = a_sat[15] ? -a_sat : a_sat;
  end

  assign mq_nxt = {16'd0, mag_r} * {14'd0, HALF_Q};
  assign rm_nxt = {14'd0, mag_r} * {14'd0, HALF_R} + HALF_RND;
  assign qprod  = {20'd0, rm_r[28:DIV_SHIFT]} * {19'd0, RECIP_45};

  assign theta_sum = mq2_r + {17'd0, quo_r};
  assign theta_nxt = neg2_r ? -$signed({3'b000, theta_sum}) : $signed({3'b000, theta_sum});

  always_ff @(posedge clk) begin
    if (en) begin
      mag_r   <= a_abs[14:0];
      neg0_r  <= a_sat[15];
      mq_r    <= mq_nxt;
      rm_r    <= rm_nxt;
      neg1_r  <= neg0_r;
      mq2_r   <= mq_r;
      quo_r   <= qprod[38:RECIP_SHIFT];
      neg2_r  <= neg1_r;
      theta_r <= theta_nxt;
    end
  end

  // Stage inputs: the first stage starts from the gain-corrected unit vector
  always_comb begin
    xin[0] = GAIN_Q30;
    yin[0] = '0;
    zin[0] = theta_r;
    for (int k = 1; k < CORDIC_N; k++) begin
      xin[k] = cx_r[k-1];
      yin[k] = cy_r[k-1];
      zin[k] = cz_r[k-1];
    end
  end

  // One rotation per stage; rotate toward zero residual angle
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < CORDIC_N; k++) begin
        if (!zin[k][CW-1]) begin
          cx_r[k] <= xin[k] - (yin[k] >>> k);
          cy_r[k] <= yin[k] + (xin[k] >>> k);
          cz_r[k] <= zin[k] - $signed({2'b00, atan_q30(k)});
        end else begin
          cx_r[k] <= xin[k] + (yin[k] >>> k);
          cy_r[k] <= yin[k] - (xin[k] >>> k);
          cz_r[k] <= zin[k] + $signed({2'b00, atan_q30(k)});
        end
      end
    end
  end

  // Clamp to the unit range
  always_comb begin
    if (cx_r[CORDIC_N-1] > ONE_Q30) begin
      cos_q30 = ONE_Q30[31:0];
    end else if (cx_r[CORDIC_N-1] < -ONE_Q30) begin
      cos_q30 = -ONE_Q30[31:0];
    end else begin
      cos_q30 = cx_r[CORDIC_N-1][31:0];
    end
    if (cy_r[CORDIC_N-1] > ONE_Q30) begin
      sin_q30 = ONE_Q30[31:0];
    end else if (cy_r[CORDIC_N-1] < -ONE_Q30) begin
      sin_q30 = -ONE_Q30[31:0];
    end else begin
      sin_q30 = cy_r[CORDIC_N-1][31:0];
    end
  end

endmodule

>>> hdl/e2q_merge.sv
// Merge stage: pair and triple products of the lane results, then output rounding.
module e2q_merge
  import e2q_pkg::*;
(
  input  logic               clk,
  input  logic               en,
  input  logic signed [31:0] cr,
  input  logic signed [31:0] sr,
  input  logic signed [31:0] cp,
  input  logic signed [31:0] sp,
  input  logic signed [31:0] cy,
  input  logic signed [31:0] sy,
  output quat_t              quat
);

  localparam int OUT_SHIFT = 30 - OUT_FRAC_BITS;
  localparam logic signed [33:0] OUT_LIM = 34'sd1 <<< OUT_FRAC_BITS;

  logic signed [31:0] pcc_r, pss_r, psc_r, pcs_r, cy_r, sy_r;
  logic signed [31:0] tccc_r, tsss_r, tscc_r, tcss_r, tcsc_r, tscs_r, tccs_r, tssc_r;

  // Q30 x Q30 product rounded half up back to Q30
  function automatic logic signed [31:0] rnd_q30(input logic signed [63:0] p);
    logic signed [63:0] s;
    s = (p + 64'sd536870912) >>> 30;
    return s[31:0];
  endfunction

  // Sum two triple products, round to the output format and clamp
  function automatic logic signed [15:0] to_out(input logic signed [31:0] a,
                                                input logic signed [31:0] b,
                                                input logic               sub);
    logic signed [32:0] v;
    logic signed [33:0] w;
    logic signed [33:0] r;
    v = sub ? (33'(a) - 33'(b)) : (33'(a) + 33'(b));
    w = (34'(v) <<< 1) + 34'sd1;
    r = w >>> (OUT_SHIFT + 1);
    if (r > OUT_LIM) begin
      r = OUT_LIM;
    end else if (r < -OUT_LIM) begin
      r = -OUT_LIM;
    end
    return r[15:0];
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      pcc_r  <= rnd_q30(64'(cr) * 64'(cp));
      pss_r  <= rnd_q30(64'(sr) * 64'(sp));
      psc_r  <= rnd_q30(64'(sr) * 64'(cp));
      pcs_r  <= rnd_q30(64'(cr) * 64'(sp));
      cy_r   <= cy;
      sy_r   <= sy;
      tccc_r <= rnd_q30(64'(pcc_r) * 64'(cy_r));
      tsss_r <= rnd_q30(64'(pss_r) * 64'(sy_r));
      tscc_r <= rnd_q30(64'(psc_r) * 64'(cy_r));
      tcss_r <= rnd_q30(64'(pcs_r) * 64'(sy_r));
      tcsc_r <= rnd_q30(64'(pcs_r) * 64'(cy_r));
      tscs_r <= rnd_q30(64'(psc_r) * 64'(sy_r));
      tccs_r <= rnd_q30(64'(pcc_r) * 64'(sy_r));
      tssc_r <= rnd_q30(64'(pss_r) * 64'(cy_r));
    end
  end

  always_comb begin
    quat.quat_real = to_out(tccc_r, tsss_r, 1'b0);
    quat.quat_x    = to_out(tscc_r, tcss_r, 1'b1);
    quat.quat_y    = to_out(tcsc_r, tscs_r, 1'b0);
    quat.quat_z    = to_out(tccs_r, tssc_r, 1'b1);
  end

endmodule

>>> hdl/euler_to_quaternion.sv
// Top level: Euler angles (roll, pitch, yaw) to a unit quaternion, one item per clock unless stalled.
//
// Fully pipelined converter: one item is accepted per clock and results leave in
// order, one per item. Three angle lanes run side by side, each saturating its
// angle to +-180 degrees, halving it into Q30 radians (4 stages) and running a
// CORDIC rotation with one register per iteration (CORDIC_STAGES stages, at most
// 24). The merge forms the four pair products and then the eight triple products
// (2 stages, one 32x32 multiply per term per stage) and rounds the sums into
// Q1.OUT_FRAC_BITS on the way into the output register. The whole pipeline
// advances together; a two-entry output buffer keeps it moving while one result
// waits, so in_ready only falls when both buffer entries are full and a further
// item is at the end of the pipeline. The block holds no state between items
// and needs no clearing after reset.
module euler_to_quaternion
  import e2q_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  angles_t in_data,
  output logic    out_valid,
  input  logic    out_ready,
  output quat_t   out_data
);

  localparam int LAST = PIPE_DEPTH - 1;

  logic [PIPE_DEPTH-1:0] valid_r;
  logic                  en;
  logic                  push;
  logic                  pop;

  logic signed [31:0] cr, sr, cp, sp, cy, sy;
  quat_t              quat;

  quat_t out_data_r, out_data_nxt;
  logic  out_valid_r, out_valid_nxt;
  quat_t skid_data_r, skid_data_nxt;
  logic  skid_valid_r, skid_valid_nxt;

  // Advance the pipeline unless the buffer is full and an item waits at the end
  assign en       = !(skid_valid_r && valid_r[LAST]);
  assign in_ready = en;
  assign push     = en && valid_r[LAST];
  assign pop      = out_valid_r && out_ready;

  // One lane per angle
  e2q_lane u_lane_roll (
    .clk     (clk),
    .en      (en),
    .angle   (in_data.angle_roll),
    .cos_q30 (cr),
    .sin_q30 (sr)
  );

  e2q_lane u_lane_pitch (
    .clk     (clk),
    .en      (en),
    .angle   (in_data.angle_pitch),
    .cos_q30 (cp),
    .sin_q30 (sp)
  );

  e2q_lane u_lane_yaw (
    .clk     (clk),
    .en      (en),
    .angle   (in_data.angle_yaw),
    .cos_q30 (cy),
    .sin_q30 (sy)
  );

  // Combine the half-angle sines and cosines into the quaternion
  e2q_merge u_merge (
    .clk  (clk),
    .en   (en),
    .cr   (cr),
    .sr   (sr),
    .cp   (cp),
    .sp   (sp),
    .cy   (cy),
    .sy   (sy),
    .quat (quat)
  );

  // Track which pipeline stages hold an item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (en) begin
      valid_r <= {valid_r[PIPE_DEPTH-2:0], in_valid};
    end
  end

  // Two-entry output buffer: the head drives the port, the skid entry catches
  // an item pushed while the head is stalled
  always_comb begin
    out_data_nxt   = out_data_r;
    out_valid_nxt  = out_valid_r;
    skid_data_nxt  = skid_data_r;
    skid_valid_nxt = skid_valid_r;
    if (!out_valid_r || pop) begin
      if (skid_valid_r) begin
        out_data_nxt   = skid_data_r;
        out_valid_nxt  = 1'b1;
        skid_data_nxt  = quat;
        skid_valid_nxt = push;
      end else begin
        out_data_nxt  = quat;
        out_valid_nxt = push;
      end
    end else if (!skid_valid_r) begin
      skid_data_nxt  = quat;
      skid_valid_nxt = push;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The skid entry is only ever filled behind a valid head
  a_skid_behind_head: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry valid while head is empty");

  // Never push into a full buffer that is not draining
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && !out_ready) |-> !push)
    else $error("push into full output buffer");

  // An accepted item occupies the first stage on the next cycle
  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> valid_r[0])
    else $error("accepted item lost at pipeline entry");

  // After a push, the head holds a valid result on the next cycle
  a_push_presents: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> out_valid_r)
    else $error("pushed result not presented");

endmodule
